[hdl/lik_pkg.sv]
// ----------------------------------------------------------------------------
// lik_pkg
// Shared widths, latencies, angle constants and the CORDIC arctangent table
// for the leg inverse kinematics pipeline.
// ----------------------------------------------------------------------------
package lik_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int CORDIC_ITERS  = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;
  localparam int NORM_STEPS    = 5;
  localparam int CORDIC_LAT    = 1 + NORM_STEPS + CORDIC_ITERS;
  localparam int CORDIC_IN_W   = 32;
  localparam int CW            = 36;

  localparam int SQRT_IN_W  = 62;
  localparam int SQRT_OUT_W = 31;
  localparam int SQRT_LAT   = SQRT_OUT_W;

  localparam int NUM_W   = 52;
  localparam int DEN_W   = 47;
  localparam int QBITS   = 30;
  localparam int RATIO_W = 32;
  localparam int DIV_LAT = QBITS + 2;

  localparam int ACOS_LAT = 2 + SQRT_LAT + CORDIC_LAT;

  localparam logic signed [CW-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [CW-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [RATIO_W-1:0] ONE_Q30 = 32'sd1073741824;

  localparam logic [1:0] REG_HIP   = 2'd0;
  localparam logic [1:0] REG_THIGH = 2'd1;
  localparam logic [1:0] REG_SHIN  = 2'd2;

  function automatic logic [29:0] atan_entry(input int i);
    case (i)
      0:  return 30'h3243F6A8;
      1:  return 30'h1DAC6705;
      2:  return 30'h0FADBAFC;
      3:  return 30'h07F56EA6;
      4:  return 30'h03FEAB76;
      5:  return 30'h01FFD55B;
      6:  return 30'h00FFFAAA;
      7:  return 30'h007FFF55;
      8:  return 30'h003FFFEA;
      9:  return 30'h001FFFFD;
      10: return 30'h000FFFFF;
      11: return 30'h0007FFFF;
      12: return 30'h0003FFFF;
      13: return 30'h0001FFFF;
      14: return 30'h0000FFFF;
      15: return 30'h00007FFF;
      16: return 30'h00003FFF;
      17: return 30'h00001FFF;
      18: return 30'h00000FFF;
      19: return 30'h000007FF;
      20: return 30'h000003FF;
      21: return 30'h000001FF;
      22: return 30'h000000FF;
      23: return 30'h0000007F;
      default: return '0;
    endcase
  endfunction

endpackage

[hdl/lik_isqrt.sv]
// ----------------------------------------------------------------------------
// lik_isqrt
// Pipelined integer square root, floor(sqrt(rad)), one root bit per stage.
// ----------------------------------------------------------------------------
module lik_isqrt import lik_pkg::*; (
  input  logic                  clk,
  input  logic                  en,
  input  logic [SQRT_IN_W-1:0]  rad,
  output logic [SQRT_OUT_W-1:0] root
);

  localparam logic [SQRT_IN_W:0]    ONE_W = 1;
  localparam logic [SQRT_OUT_W-1:0] ONE_R = 1;

  logic [SQRT_IN_W-1:0]  rem_q [SQRT_LAT];
  logic [SQRT_OUT_W-1:0] rt_q  [SQRT_LAT];

  for (genvar j = 0; j < SQRT_LAT; j++) begin : g_stage
    localparam int B = SQRT_OUT_W - 1 - j;
    logic [SQRT_IN_W-1:0]  rem_in;
    logic [SQRT_OUT_W-1:0] rt_in;
    logic [SQRT_IN_W:0]    trial;
    logic [SQRT_IN_W:0]    rem_ext;

    if (j == 0) begin : g_first
      assign rem_in = rad;
      assign rt_in  = '0;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign rt_in  = rt_q[j-1];
    end

    assign rem_ext = {1'b0, rem_in};
    assign trial   = ({{(SQRT_IN_W+1-SQRT_OUT_W){1'b0}}, rt_in} << (B + 1)) | (ONE_W << (2 * B));

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_ext >= trial) begin
          rem_q[j] <= SQRT_IN_W'(rem_ext - trial);
          rt_q[j]  <= rt_in | (ONE_R << B);
        end else begin
          rem_q[j] <= rem_in;
          rt_q[j]  <= rt_in;
        end
      end
    end
  end

  assign root = rt_q[SQRT_LAT-1];

endmodule

[hdl/lik_cordic.sv]
// ----------------------------------------------------------------------------
// lik_cordic
// Pipelined CORDIC vectoring unit: atan2(y, x) in Q6.30 radians, with
// half-plane fold, staged normalization and one micro-rotation per stage.
// ----------------------------------------------------------------------------
module lik_cordic import lik_pkg::*; (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [CORDIC_IN_W-1:0] y_in,
  input  logic signed [CORDIC_IN_W-1:0] x_in,
  output logic signed [CW-1:0]          angle
);

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 zero;
  } cs_t;

  cs_t st [CORDIC_LAT];

  logic signed [CW-1:0] xe, ye;
  assign xe = CW'(x_in);
  assign ye = CW'(y_in);

  always_ff @(posedge clk) begin
    if (en) begin
      st[0].zero <= (x_in == '0) && (y_in == '0);
      if (x_in < 0) begin
        st[0].x <= -xe;
        st[0].y <= -ye;
        st[0].z <= (y_in >= 0) ? PI_Q30 : -PI_Q30;
      end else begin
        st[0].x <= xe;
        st[0].y <= ye;
        st[0].z <= '0;
      end
    end
  end

  // shift by S while the larger magnitude stays below 2^29 after S - 1 doublings
  for (genvar n = 1; n <= NORM_STEPS; n++) begin : g_norm
    localparam int S = 16 >> (n - 1);
    localparam logic signed [CW-1:0] LIM = CW'(1) << (30 - S);
    logic ok;
    assign ok = (st[n-1].x < LIM) && (st[n-1].y < LIM) && (st[n-1].y > -LIM);

    always_ff @(posedge clk) begin
      if (en) begin
        st[n].zero <= st[n-1].zero;
        st[n].z    <= st[n-1].z;
        if (ok) begin
          st[n].x <= st[n-1].x <<< S;
          st[n].y <= st[n-1].y <<< S;
        end else begin
          st[n].x <= st[n-1].x;
          st[n].y <= st[n-1].y;
        end
      end
    end
  end

  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
    localparam int K = NORM_STEPS + 1 + i;
    localparam logic signed [CW-1:0] ATAN_I = CW'(atan_entry(i));
    logic signed [CW-1:0] dx, dy;
    assign dx = st[K-1].y >>> i;
    assign dy = st[K-1].x >>> i;

    always_ff @(posedge clk) begin
      if (en) begin
        st[K].zero <= st[K-1].zero;
        if (st[K-1].y > 0) begin
          st[K].x <= st[K-1].x + dx;
          st[K].y <= st[K-1].y - dy;
          st[K].z <= st[K-1].z + ATAN_I;
        end else begin
          st[K].x <= st[K-1].x - dx;
          st[K].y <= st[K-1].y + dy;
          st[K].z <= st[K-1].z - ATAN_I;
        end
      end
    end
  end

  assign angle = st[CORDIC_LAT-1].zero ? '0 : st[CORDIC_LAT-1].z;

endmodule

[hdl/lik_divider.sv]
// ----------------------------------------------------------------------------
// lik_divider
// Pipelined restoring divider producing a signed Q2.30 ratio clamped to
// [-1, 1], with an out-of-range flag.
// ----------------------------------------------------------------------------
module lik_divider import lik_pkg::*; (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [NUM_W-1:0]   num,
  input  logic        [DEN_W-1:0]   den,
  output logic signed [RATIO_W-1:0] ratio,
  output logic                      flag
);

  typedef struct packed {
    logic [DEN_W-1:0] r;
    logic [DEN_W-1:0] den;
    logic [QBITS-1:0] q;
    logic             neg;
    logic             sat;
    logic             flg;
  } dv_t;

  dv_t st [QBITS+1];

  logic [NUM_W-1:0] mag;
  logic [NUM_W-1:0] den_ext;
  assign mag     = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign den_ext = {{(NUM_W-DEN_W){1'b0}}, den};

  always_ff @(posedge clk) begin
    if (en) begin
      st[0].r   <= mag[DEN_W-1:0];
      st[0].den <= den;
      st[0].q   <= '0;
      st[0].neg <= num[NUM_W-1];
      st[0].sat <= (den == '0) || (mag >= den_ext);
      st[0].flg <= (den == '0) || (mag > den_ext);
    end
  end

  for (genvar j = 1; j <= QBITS; j++) begin : g_step
    logic [DEN_W:0] rs;
    assign rs = {st[j-1].r, 1'b0};

    always_ff @(posedge clk) begin
      if (en) begin
        st[j].den <= st[j-1].den;
        st[j].neg <= st[j-1].neg;
        st[j].sat <= st[j-1].sat;
        st[j].flg <= st[j-1].flg;
        if (rs >= {1'b0, st[j-1].den}) begin
          st[j].r <= DEN_W'(rs - {1'b0, st[j-1].den});
          st[j].q <= {st[j-1].q[QBITS-2:0], 1'b1};
        end else begin
          st[j].r <= rs[DEN_W-1:0];
          st[j].q <= {st[j-1].q[QBITS-2:0], 1'b0};
        end
      end
    end
  end

  logic signed [RATIO_W-1:0] qs;
  assign qs = $signed({{(RATIO_W-QBITS){1'b0}}, st[QBITS].q});

  always_ff @(posedge clk) begin
    if (en) begin
      flag <= st[QBITS].flg;
      if (st[QBITS].sat) begin
        ratio <= st[QBITS].neg ? -ONE_Q30 : ONE_Q30;
      end else begin
        ratio <= st[QBITS].neg ? -qs : qs;
      end
    end
  end

endmodule

[hdl/lik_acos.sv]
// ----------------------------------------------------------------------------
// lik_acos
// Pipelined arccosine of a Q2.30 argument as atan2(sqrt(1 - r^2), r).
// ----------------------------------------------------------------------------
module lik_acos import lik_pkg::*; (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [RATIO_W-1:0] r,
  output logic signed [CW-1:0]      angle
);

  localparam logic [SQRT_IN_W-1:0] ONE_SQ = SQRT_IN_W'(1) << 60;

  logic [RATIO_W-1:0]      r_abs;
  logic [60:0]             mm_q;
  logic [SQRT_IN_W-1:0]    rad_q;
  logic signed [RATIO_W-1:0] r1, r2;
  logic signed [RATIO_W-1:0] rd [SQRT_LAT];
  logic [SQRT_OUT_W-1:0]   root;

  assign r_abs = r[RATIO_W-1] ? RATIO_W'(-r) : RATIO_W'(r);

  always_ff @(posedge clk) begin
    if (en) begin
      mm_q  <= r_abs[30:0] * r_abs[30:0];
      r1    <= r;
      rad_q <= ONE_SQ - {1'b0, mm_q};
      r2    <= r1;
      rd[0] <= r2;
      for (int i = 1; i < SQRT_LAT; i++) begin
        rd[i] <= rd[i-1];
      end
    end
  end

  lik_isqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (rad_q),
    .root (root)
  );

  lik_cordic u_cordic (
    .clk   (clk),
    .en    (en),
    .y_in  ($signed({1'b0, root})),
    .x_in  (rd[SQRT_LAT-1]),
    .angle (angle)
  );

endmodule

[hdl/leg_inverse_kinematics_top.sv]
// ----------------------------------------------------------------------------
// leg_inverse_kinematics_top
// Three-joint leg inverse kinematics: foot target in, joint angles out.
//
// Accepts one foot target per clock unless stalled and returns one set of hip,
// knee and ankle angles per target, in order, computed by two 31-stage square
// roots, two 32-stage dividers and two arccosine units (square root plus
// CORDIC). The output register stalls the whole pipeline when m_tvalid is high
// and m_tready is low. Link lengths must be written through the cfg port only
// while no transaction is in flight; the block itself does not enforce this.
// unreachable flags an arccosine ratio beyond [-1, 1] or a zero divisor.
// ----------------------------------------------------------------------------
module leg_inverse_kinematics_top import lik_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // target_x, target_y, target_z
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // hip_angle, knee_angle, ankle_angle
  output logic        m_tuser,   // unreachable
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  localparam int FRONT = 2 + SQRT_LAT;
  localparam int TOTAL = 3 + SQRT_LAT + 3 + SQRT_LAT + 1 + DIV_LAT + ACOS_LAT + 1;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
    logic        [46:0] zz;
  } side_a_t;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
    logic signed [25:0] d;
    logic        [49:0] lr2;
  } side_b_t;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
    logic signed [25:0] d;
    logic               flag;
  } side_c_t;

  function automatic logic signed [15:0] to_q12(input logic signed [CW:0] a);
    logic signed [CW:0]    rnd;
    logic signed [CW-18:0] sh;
    begin
      rnd = a + 131072;
      sh  = rnd[CW:18];
      if (sh > 32767) begin
        return 16'sh7FFF;
      end else if (sh < -32768) begin
        return -16'sh8000;
      end else begin
        return sh[15:0];
      end
    end
  endfunction

  logic en;
  logic [TOTAL-1:0] vld;

  logic [19:0] hip_len, thigh_len, shin_len;
  logic [39:0] tt_q, ss_q, ts_prod;
  logic [40:0] ts2_q;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hip_len   <= '0;
      thigh_len <= '0;
      shin_len  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HIP:   hip_len   <= cfg_data;
        REG_THIGH: thigh_len <= cfg_data;
        REG_SHIN:  shin_len  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign ts_prod = thigh_len * shin_len;

  always_ff @(posedge clk) begin
    tt_q  <= thigh_len * thigh_len;
    ss_q  <= shin_len * shin_len;
    ts2_q <= {ts_prod, 1'b0};
  end

  // pipeline control
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[TOTAL-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[TOTAL-2:0], s_tvalid};
    end
  end

  // squares and planar reach
  logic signed [23:0] x1, y1, z1, x2, y2, z2, x3, y3, z3;
  logic signed [47:0] xs, ys, zs, pxx, pyy, pzz;
  logic [46:0] xx2, yy2, zz2, zz3;
  logic [47:0] sxy3;

  assign xs  = 48'(x1);
  assign ys  = 48'(y1);
  assign zs  = 48'(z1);
  assign pxx = xs * xs;
  assign pyy = ys * ys;
  assign pzz = zs * zs;

  always_ff @(posedge clk) begin
    if (en) begin
      x1   <= s_tdata[23:0];
      y1   <= s_tdata[47:24];
      z1   <= s_tdata[71:48];
      xx2  <= pxx[46:0];
      yy2  <= pyy[46:0];
      zz2  <= pzz[46:0];
      x2   <= x1;
      y2   <= y1;
      z2   <= z1;
      sxy3 <= {1'b0, xx2} + {1'b0, yy2};
      zz3  <= zz2;
      x3   <= x2;
      y3   <= y2;
      z3   <= z2;
    end
  end

  logic [SQRT_OUT_W-1:0] f1_root;
  side_a_t sa [SQRT_LAT];

  lik_isqrt u_sqrt_f1 (
    .clk  (clk),
    .en   (en),
    .rad  ({{(SQRT_IN_W-48){1'b0}}, sxy3}),
    .root (f1_root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sa[0] <= '{x: x3, y: y3, z: z3, zz: zz3};
      for (int i = 1; i < SQRT_LAT; i++) begin
        sa[i] <= sa[i-1];
      end
    end
  end

  // offset from hip and full reach
  logic signed [23:0] x4, y4, z4, x5, y5, z5, x6, y6, z6;
  logic signed [25:0] d4, d5, d6;
  logic [46:0] zz4, zz5;
  logic [48:0] dd5;
  logic [49:0] lr2_6;
  logic signed [51:0] ds, pdd;

  assign ds  = 52'(d4);
  assign pdd = ds * ds;

  always_ff @(posedge clk) begin
    if (en) begin
      d4    <= $signed({1'b0, f1_root[24:0]} - {6'd0, hip_len});
      x4    <= sa[SQRT_LAT-1].x;
      y4    <= sa[SQRT_LAT-1].y;
      z4    <= sa[SQRT_LAT-1].z;
      zz4   <= sa[SQRT_LAT-1].zz;
      dd5   <= pdd[48:0];
      d5    <= d4;
      zz5   <= zz4;
      x5    <= x4;
      y5    <= y4;
      z5    <= z4;
      lr2_6 <= {1'b0, dd5} + {3'd0, zz5};
      d6    <= d5;
      x6    <= x5;
      y6    <= y5;
      z6    <= z5;
    end
  end

  logic [SQRT_OUT_W-1:0] lr_root;
  side_b_t sb [SQRT_LAT];

  lik_isqrt u_sqrt_lr (
    .clk  (clk),
    .en   (en),
    .rad  ({{(SQRT_IN_W-50){1'b0}}, lr2_6}),
    .root (lr_root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sb[0] <= '{x: x6, y: y6, z: z6, d: d6, lr2: lr2_6};
      for (int i = 1; i < SQRT_LAT; i++) begin
        sb[i] <= sb[i-1];
      end
    end
  end

  // law-of-cosines numerators and denominators
  logic [NUM_W-1:0] lr2_ext, tt_ext, ss_ext;
  logic [45:0] lrt;
  logic signed [NUM_W-1:0] numk7, numa7;
  logic [DEN_W-1:0] denk7, dena7;
  side_c_t sc7;

  assign lr2_ext = {{(NUM_W-50){1'b0}}, sb[SQRT_LAT-1].lr2};
  assign tt_ext  = {{(NUM_W-40){1'b0}}, tt_q};
  assign ss_ext  = {{(NUM_W-40){1'b0}}, ss_q};
  assign lrt     = lr_root[24:0] * thigh_len;

  always_ff @(posedge clk) begin
    if (en) begin
      numk7 <= $signed(lr2_ext + tt_ext - ss_ext);
      numa7 <= $signed(lr2_ext - tt_ext - ss_ext);
      denk7 <= {lrt, 1'b0};
      dena7 <= {{(DEN_W-41){1'b0}}, ts2_q};
      sc7   <= '{x: sb[SQRT_LAT-1].x, y: sb[SQRT_LAT-1].y, z: sb[SQRT_LAT-1].z,
                 d: sb[SQRT_LAT-1].d, flag: 1'b0};
    end
  end

  logic signed [RATIO_W-1:0] rk, ra;
  logic fk, fa;
  side_c_t sc [DIV_LAT];

  lik_divider u_div_knee (
    .clk   (clk),
    .en    (en),
    .num   (numk7),
    .den   (denk7),
    .ratio (rk),
    .flag  (fk)
  );

  lik_divider u_div_ankle (
    .clk   (clk),
    .en    (en),
    .num   (numa7),
    .den   (dena7),
    .ratio (ra),
    .flag  (fa)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sc[0] <= sc7;
      for (int i = 1; i < DIV_LAT; i++) begin
        sc[i] <= sc[i-1];
      end
    end
  end

  // angle units
  logic signed [CW-1:0] acos_k, acos_a, hip_ang, knee_off;
  side_c_t sd [FRONT];
  logic [CORDIC_LAT-1:0] flag_d;
  logic signed [CORDIC_IN_W-1:0] hip_y, hip_x, kn_y, kn_x;

  lik_acos u_acos_knee (
    .clk   (clk),
    .en    (en),
    .r     (rk),
    .angle (acos_k)
  );

  lik_acos u_acos_ankle (
    .clk   (clk),
    .en    (en),
    .r     (ra),
    .angle (acos_a)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0]      <= '{x: sc[DIV_LAT-1].x, y: sc[DIV_LAT-1].y, z: sc[DIV_LAT-1].z,
                      d: sc[DIV_LAT-1].d, flag: fk | fa};
      for (int i = 1; i < FRONT; i++) begin
        sd[i] <= sd[i-1];
      end
      flag_d <= {flag_d[CORDIC_LAT-2:0], sd[FRONT-1].flag};
    end
  end

  assign hip_y = CORDIC_IN_W'(sd[FRONT-1].y);
  assign hip_x = CORDIC_IN_W'(sd[FRONT-1].x);
  assign kn_y  = CORDIC_IN_W'(sd[FRONT-1].z);
  assign kn_x  = -(CORDIC_IN_W'(sd[FRONT-1].d));

  lik_cordic u_cordic_hip (
    .clk   (clk),
    .en    (en),
    .y_in  (hip_y),
    .x_in  (hip_x),
    .angle (hip_ang)
  );

  lik_cordic u_cordic_knee (
    .clk   (clk),
    .en    (en),
    .y_in  (kn_y),
    .x_in  (kn_x),
    .angle (knee_off)
  );

  // output register
  logic signed [CW:0] knee_sum, ankle_sum;
  logic signed [15:0] hip_o, knee_o, ankle_o;
  logic unr_o;

  assign knee_sum  = (CW+1)'(acos_k) - (CW+1)'(knee_off);
  assign ankle_sum = (CW+1)'(acos_a) - (CW+1)'(HALF_PI_Q30);

  always_ff @(posedge clk) begin
    if (en) begin
      hip_o   <= to_q12((CW+1)'(hip_ang));
      knee_o  <= to_q12(knee_sum);
      ankle_o <= to_q12(ankle_sum);
      unr_o   <= flag_d[CORDIC_LAT-1];
    end
  end

  assign m_tdata = {ankle_o, knee_o, hip_o};
  assign m_tuser = unr_o;

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for leg_inverse_kinematics_top. A directed table covers zero
// and maximum link lengths, coordinate extremes, a fully stretched leg and
// targets out of reach. A random phase follows, under several link settings,
// with most targets in a cube around the reach sphere. Each transaction is
// checked field by field against an in-bench fixed-point predictor, with
// random gaps on the input stream and random stalls on the output stream.
// ----------------------------------------------------------------------------
module tb;
  import lik_pkg::*;

  localparam int PIPE_LAT    = 141 + CORDIC_STAGES;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int RAND_ITEMS  = 700;
  localparam int NO_FLAG     = 2;

  typedef struct packed {
    logic [15:0] hip;
    logic [15:0] knee;
    logic [15:0] ankle;
    logic        unreach;
  } joints_t;

  typedef struct {
    logic [19:0] hip_len;
    logic [19:0] thigh_len;
    logic [19:0] shin_len;
    int          tx;
    int          ty;
    int          tz;
    int          exp_flag;
  } vector_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [71:0] s_tdata;    // target_x, target_y, target_z
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;    // hip_angle, knee_angle, ankle_angle
  logic        m_tuser;    // unreachable
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [19:0] cfg_data;

  logic [19:0] cur_hip, cur_thigh, cur_shin;
  joints_t     pending_joints[$];
  int          errors;
  int          cycles;
  int          stall_left;
  bit          no_idle;

  leg_inverse_kinematics_top dut (.*);

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root, bit_v;
    root  = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > n) bit_v >>= 2;
    while (bit_v != 0) begin
      if (n >= root + bit_v) begin
        n    = n - (root + bit_v);
        root = (root >> 1) + bit_v;
      end else begin
        root >>= 1;
      end
      bit_v >>= 2;
    end
    return root;
  endfunction

  function automatic longint abs_l(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint base, acc, dx, dy;
    base = 0;
    acc  = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      x    = -x;
      y    = -y;
      base = (y <= 0) ? longint'(PI_Q30) : -longint'(PI_Q30);
    end
    while (abs_l(x) < (64'sd1 <<< 29) && abs_l(y) < (64'sd1 <<< 29)) begin
      x = x * 2;
      y = y * 2;
    end
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x   = x + dx;
        y   = y - dy;
        acc = acc + longint'(atan_entry(i));
      end else begin
        x   = x - dx;
        y   = y + dy;
        acc = acc - longint'(atan_entry(i));
      end
    end
    return base + acc;
  endfunction

  function automatic longint cos_ratio(longint num, longint den, ref bit flag);
    longint unsigned mag, r, q;
    mag = abs_l(num);
    q   = 0;
    if (den == 0 || mag >= den) begin
      if (den == 0 || mag > den) flag = 1'b1;
      return (num >= 0) ? longint'(ONE_Q30) : -longint'(ONE_Q30);
    end
    r = mag;
    for (int i = 0; i < 30; i++) begin
      r <<= 1;
      q <<= 1;
      if (r >= den) begin
        r = r - den;
        q |= 1;
      end
    end
    return (num >= 0) ? longint'(q) : -longint'(q);
  endfunction

  function automatic longint arc_cos(longint r);
    longint unsigned m;
    m = abs_l(r);
    return vector_angle(longint'(int_sqrt((64'd1 << 60) - m * m)), r);
  endfunction

  function automatic logic [15:0] to_q412(longint a);
    longint v;
    v = (a + (64'sd1 <<< 17)) >>> 18;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic joints_t predict_joints(longint x, longint y, longint z);
    joints_t j;
    longint  h, t, s, f1, d, lr2, lr, rk, ra;
    bit      flag;
    h    = cur_hip;
    t    = cur_thigh;
    s    = cur_shin;
    flag = 1'b0;
    f1   = int_sqrt(x * x + y * y);
    d    = f1 - h;
    lr2  = d * d + z * z;
    lr   = int_sqrt(lr2);
    rk   = cos_ratio(lr2 + t * t - s * s, 2 * lr * t, flag);
    ra   = cos_ratio(lr2 - t * t - s * s, 2 * t * s, flag);
    j.hip     = to_q412(vector_angle(y, x));
    j.knee    = to_q412(arc_cos(rk) - vector_angle(z, -d));
    j.ankle   = to_q412(arc_cos(ra) - longint'(HALF_PI_Q30));
    j.unreach = flag;
    return j;
  endfunction

  task automatic report_mismatch(string field, logic [15:0] got, logic [15:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $time, field, got, want);
    errors++;
  endtask

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 120);
  endfunction

  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_tready = 1'b0;
      stall_left--;
    end else begin
      m_tready = 1'b1;
      if (!no_idle && $urandom_range(0, 7) == 0) stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(posedge clk) begin
    joints_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_joints.size() == 0) begin
        report_mismatch("unexpected transaction", m_tdata[15:0], 16'h0);
      end else begin
        want = pending_joints.pop_front();
        if (m_tdata[15:0] !== want.hip)
          report_mismatch("hip_angle", m_tdata[15:0], want.hip);
        if (m_tdata[31:16] !== want.knee)
          report_mismatch("knee_angle", m_tdata[31:16], want.knee);
        if (m_tdata[47:32] !== want.ankle)
          report_mismatch("ankle_angle", m_tdata[47:32], want.ankle);
        if (m_tuser !== want.unreach)
          report_mismatch("unreachable", {15'h0, m_tuser}, {15'h0, want.unreach});
      end
    end
  end

  // entered and left at a falling edge
  task automatic write_reg(logic [1:0] idx, logic [19:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic drain();
    while (pending_joints.size() != 0) @(negedge clk);
    repeat (PIPE_LAT) @(negedge clk);
  endtask

  task automatic set_links(logic [19:0] h, logic [19:0] t, logic [19:0] s);
    drain();
    write_reg(REG_HIP, h);
    write_reg(REG_THIGH, t);
    write_reg(REG_SHIN, s);
    cur_hip   = h;
    cur_thigh = t;
    cur_shin  = s;
  endtask

  task automatic send_target(int x, int y, int z, int exp_flag);
    int      gap;
    joints_t want;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {z[23:0], y[23:0], x[23:0]};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    // the block sees only the low 24 bits of each coordinate
    want = predict_joints(longint'($signed(x[23:0])), longint'($signed(y[23:0])),
                          longint'($signed(z[23:0])));
    if (exp_flag != NO_FLAG && want.unreach != exp_flag[0])
      report_mismatch("table flag", {15'h0, want.unreach}, exp_flag[15:0]);
    pending_joints.push_back(want);
    @(negedge clk);
  endtask

  function automatic int near_coord(int reach);
    int v;
    v = int'($urandom_range(0, 2 * reach)) - reach;
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v;
  endfunction

  function automatic logic [19:0] rand_len();
    case ($urandom_range(0, 5))
      0:       return 20'h0;
      1:       return 20'hFFFFF;
      2:       return $urandom_range(0, 20'hFFFFF);
      default: return $urandom_range(256, 65535);
    endcase
  endfunction

  localparam int H = 8192, T = 20480, S = 25600, R = H + T + S;
  localparam int XMAX = 8388607, XMIN = -8388608;

  vector_t table_rows[] = '{
    '{20'h0, 20'h0, 20'h0, 0, 0, 0, 1},
    '{20'h0, 20'h0, 20'h0, XMAX, XMAX, XMAX, 1},
    '{20'h0, 20'h0, 20'h0, XMIN, XMIN, XMIN, 1},
    '{20'h0, 20'h0, 20'h0, -1000, 0, 500, 1},
    '{H, T, S, R, 0, 0, 0},
    '{H, T, S, R + 1000, 0, 0, 1},
    '{H, T, S, H + 30000, 0, -30000, NO_FLAG},
    '{H, T, S, 0, H + 20000, 15000, NO_FLAG},
    '{H, T, S, -(H + 25000), 0, 10000, NO_FLAG},
    '{H, T, S, -20000, -20000, -5000, NO_FLAG},
    '{H, T, S, 0, 0, 0, NO_FLAG},
    '{H, T, S, XMAX, XMIN, XMAX, 1},
    '{H, T, S, XMIN, XMAX, XMIN, 1},
    '{H, 20'h0, S, 20000, 10000, 0, 1},
    '{H, T, 20'h0, 20000, 10000, 0, NO_FLAG},
    '{20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 0, 0, 0, NO_FLAG},
    '{20'hFFFFF, 20'hFFFFF, 20'hFFFFF, XMAX, XMAX, XMIN, NO_FLAG},
    '{20'hFFFFF, 20'hFFFFF, 20'hFFFFF, XMIN, 0, XMAX, NO_FLAG},
    '{20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 1048575, -1048575, 0, NO_FLAG}
  };

  initial begin
    int reach;
    errors     = 0;
    cycles     = 0;
    stall_left = 0;
    no_idle    = 1'b0;
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    m_tready   = 1'b1;
    cfg_valid  = 1'b0;
    cfg_index  = REG_HIP;
    cfg_data   = '0;
    cur_hip    = '0;
    cur_thigh  = '0;
    cur_shin   = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (table_rows[i]) begin
      if (table_rows[i].hip_len != cur_hip || table_rows[i].thigh_len != cur_thigh ||
          table_rows[i].shin_len != cur_shin) begin
        s_tvalid = 1'b0;
        set_links(table_rows[i].hip_len, table_rows[i].thigh_len, table_rows[i].shin_len);
      end
      send_target(table_rows[i].tx, table_rows[i].ty, table_rows[i].tz,
                  table_rows[i].exp_flag);
    end

    for (int phase = 0; phase < 7; phase++) begin
      s_tvalid = 1'b0;
      if (phase == 0) set_links(20'hFFFFF, 20'h0, 20'hFFFFF);
      else            set_links(rand_len(), rand_len(), rand_len());
      no_idle = (phase == 3);
      reach = int'(cur_hip) + int'(cur_thigh) + int'(cur_shin) + 16;
      for (int k = 0; k < RAND_ITEMS / 7; k++) begin
        if ($urandom_range(0, 3) != 0)
          send_target(near_coord(reach), near_coord(reach), near_coord(reach), NO_FLAG);
        else
          send_target($urandom, $urandom, $urandom, NO_FLAG);
      end
    end
    s_tvalid = 1'b0;
    no_idle  = 1'b0;

    drain();
    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/lik_pkg.sv
hdl/lik_isqrt.sv
hdl/lik_cordic.sv
hdl/lik_divider.sv
hdl/lik_acos.sv
hdl/leg_inverse_kinematics_top.sv
sim/tb.sv
